[rtl/core/vfc_pkg.sv]
// ----------------------------------------------------------------------------
// vfc_pkg
// Shared types and constants of the video frame crop stream core.
// ----------------------------------------------------------------------------
package vfc_pkg;

  localparam int ColW = 17;   // byte column bounds, with lookahead margin
  localparam int RowW = 14;   // row bounds

  localparam int QDepth = 4;
  localparam int QAw    = 2;

  localparam logic [2:0] REG_TRIM_LEFT   = 3'd0;
  localparam logic [2:0] REG_TRIM_TOP    = 3'd1;
  localparam logic [2:0] REG_OUT_WIDTH   = 3'd2;
  localparam logic [2:0] REG_OUT_HEIGHT  = 3'd3;
  localparam logic [2:0] REG_BYTES_PIXEL = 3'd4;
  localparam logic [2:0] REG_LAYOUT      = 3'd5;
  localparam logic [2:0] REG_LUMA_OFFSET = 3'd6;

  localparam logic [1:0] LAYOUT_SIMPLE = 2'd0;
  localparam logic [1:0] LAYOUT_422    = 2'd1;
  localparam logic [1:0] LAYOUT_PLANAR = 2'd2;

  localparam logic [1:0] PLANE_LUMA = 2'd0;
  localparam logic [1:0] PLANE_V    = 2'd2;
  localparam logic [1:0] PLANE_NONE = 2'd3;

  // Window bounds for one plane, in bytes and rows
  typedef struct packed {
    logic [ColW-1:0] left;
    logic [ColW-1:0] left2;     // left + 2
    logic [ColW-1:0] end_col;   // left + width
    logic [ColW-1:0] end2;      // left + width + 2
    logic            nz;        // width is not zero
    logic [11:0]     top;
    logic [RowW-1:0] top_end;   // top + height
  } win_t;

  typedef struct packed {
    win_t pk;        // packed layouts
    win_t ly;        // planar luma
    win_t ch;        // planar chroma
    logic planar;
    logic odd422;
    logic luma_offset;
  } crop_cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] plane;
    logic       row_end;
    logic       frame_end;
  } item_t;

endpackage

[rtl/core/vfc_cfg.sv]
// ----------------------------------------------------------------------------
// vfc_cfg
// Configuration registers and registered window bounds per plane.
// ----------------------------------------------------------------------------
module vfc_cfg #(
  parameter int MAX_DIM = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [12:0]         cfg_data,
  output vfc_pkg::crop_cfg_t  win,
  output logic                busy
);
  import vfc_pkg::*;

  localparam logic [13:0] DimCap = 14'(MAX_DIM);

  logic [11:0] trim_left;
  logic [11:0] trim_top;
  logic [12:0] out_width;
  logic [12:0] out_height;
  logic [2:0]  bytes_per_pixel;
  logic [1:0]  layout_mode;
  logic        luma_offset;

  logic [13:0]     w_cl;
  logic [13:0]     h_cl;
  logic [11:0]     pk_px;
  logic [ColW-1:0] pk_left;
  logic [ColW-1:0] pk_width;
  crop_cfg_t       win_next;

  function automatic win_t make_win(input logic [ColW-1:0] left,
                                    input logic [ColW-1:0] width,
                                    input logic [11:0]     top,
                                    input logic [13:0]     height);
    win_t v;
    v.left    = left;
    v.left2   = left + ColW'(2);
    v.end_col = left + width;
    v.end2    = left + width + ColW'(2);
    v.nz      = (width != '0);
    v.top     = top;
    v.top_end = RowW'(top) + RowW'(height);
    return v;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trim_left       <= '0;
      trim_top        <= '0;
      out_width       <= 13'd1;
      out_height      <= 13'd1;
      bytes_per_pixel <= 3'd1;
      layout_mode     <= LAYOUT_SIMPLE;
      luma_offset     <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TRIM_LEFT:   trim_left       <= cfg_data[11:0];
        REG_TRIM_TOP:    trim_top        <= cfg_data[11:0];
        REG_OUT_WIDTH:   out_width       <= cfg_data;
        REG_OUT_HEIGHT:  out_height      <= cfg_data;
        REG_BYTES_PIXEL: bytes_per_pixel <= cfg_data[2:0];
        REG_LAYOUT:      layout_mode     <= cfg_data[1:0];
        REG_LUMA_OFFSET: luma_offset     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_cl  = ({1'b0, out_width}  > DimCap) ? DimCap : {1'b0, out_width};
    h_cl  = ({1'b0, out_height} > DimCap) ? DimCap : {1'b0, out_height};
    pk_px = (layout_mode == LAYOUT_422) ? {trim_left[11:1], 1'b0} : trim_left;
    pk_left  = ColW'(pk_px) * ColW'(bytes_per_pixel);
    pk_width = ColW'(w_cl) * ColW'(bytes_per_pixel);

    win_next.pk = make_win(pk_left, pk_width, trim_top, h_cl);
    win_next.ly = make_win(ColW'(trim_left), ColW'(w_cl), trim_top, h_cl);
    win_next.ch = make_win(ColW'(trim_left[11:1]),
                           ColW'((w_cl + 14'd1) >> 1),
                           {1'b0, trim_top[11:1]},
                           (h_cl + 14'd1) >> 1);
    win_next.planar      = (layout_mode == LAYOUT_PLANAR);
    win_next.odd422      = (layout_mode == LAYOUT_422) && trim_left[0];
    win_next.luma_offset = luma_offset;
  end

  // bounds are registered and settle in the cycle after any register change
  always_ff @(posedge clk) begin
    win  <= win_next;
    busy <= rst | (cfg_valid & cfg_ready);
  end

endmodule

[rtl/core/vfc_front.sv]
// ----------------------------------------------------------------------------
// vfc_front
// Position counters, window test and 4:2:2 lookahead; one decision per item.
// ----------------------------------------------------------------------------
module vfc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  vfc_pkg::item_t     in_item,
  input  vfc_pkg::crop_cfg_t win,
  output logic               push,
  output vfc_pkg::item_t     push_item
);
  import vfc_pkg::*;

  localparam logic [14:0] ColMax = '1;
  localparam logic [12:0] RowMax = '1;

  logic [14:0] col;
  logic [12:0] row;
  logic [1:0]  cur_plane;
  logic [7:0]  lb0;
  logic [7:0]  lb1;
  logic [1:0]  fill;

  logic [14:0] col_next;
  logic [12:0] row_next;
  logic [1:0]  cur_plane_next;
  logic [7:0]  lb0_next;
  logic [7:0]  lb1_next;
  logic [1:0]  fill_next;

  logic            chg;
  logic [14:0]     c;
  logic [12:0]     r;
  logic [1:0]      fill_a;
  logic [1:0]      fill_b;
  logic [1:0]      pl;
  win_t            ws;
  logic            plane_ok;
  logic            in_rows;
  logic            active;
  logic            last_row;
  logic            last_plane;
  logic [ColW-1:0] c17;
  logic            hit;
  logic            emit;
  logic            last_col;
  logic            luma;
  logic            brk;

  always_comb begin
    chg    = win.planar && (in_item.plane != cur_plane);
    c      = chg ? '0 : col;
    r      = chg ? '0 : row;
    fill_a = chg ? '0 : fill;
    pl     = win.planar ? in_item.plane : PLANE_LUMA;

    if (!win.planar)               ws = win.pk;
    else if (pl == PLANE_LUMA)     ws = win.ly;
    else                           ws = win.ch;
    plane_ok   = !win.planar || (pl != PLANE_NONE);
    last_plane = !win.planar || (pl == PLANE_V);

    in_rows  = ({1'b0, r} >= RowW'(ws.top)) && ({1'b0, r} < ws.top_end);
    active   = in_rows && ws.nz && plane_ok;
    last_row = ({1'b0, r} + RowW'(1)) == ws.top_end;
    c17      = ColW'(c);

    push      = 1'b0;
    push_item = '0;
    lb0_next  = lb0;
    lb1_next  = lb1;
    fill_b    = fill_a;
    hit       = 1'b0;
    emit      = 1'b0;
    last_col  = 1'b0;
    luma      = 1'b0;

    if (active && !win.odd422) begin
      hit      = (c17 >= ws.left) && (c17 < ws.end_col);
      last_col = (c17 + ColW'(1)) == ws.end_col;
      push     = in_fire && hit;
      push_item.data      = in_item.data;
      push_item.plane     = pl;
      push_item.row_end   = last_col;
      push_item.frame_end = last_col && last_plane && last_row;
    end else if (active) begin
      // odd-left 4:2:2: luma comes two bytes later, chroma from the delay line
      if (c17 == ws.left) fill_b = '0;
      emit     = (c17 >= ws.left2) && (c17 < ws.end2) && (fill_b != '0);
      last_col = (c17 + ColW'(1)) == ws.end2;
      luma     = (c[0] == win.luma_offset);
      push     = in_fire && emit;
      push_item.data      = luma ? in_item.data : lb0;
      push_item.plane     = PLANE_LUMA;
      push_item.row_end   = last_col;
      push_item.frame_end = last_col && last_row;
      if (emit) begin
        lb0_next = lb1;
        fill_b   = fill_b - 2'd1;
      end
      if ((c17 >= ws.left) && (c17 < ws.end_col) && (fill_b != 2'd2)) begin
        if (fill_b == 2'd0) lb0_next = in_item.data;
        else                lb1_next = in_item.data;
        fill_b = fill_b + 2'd1;
      end
    end

    brk = in_item.row_end || in_item.frame_end;
    col_next  = brk ? '0 : ((c == ColMax) ? c : c + 15'd1);
    fill_next = brk ? '0 : fill_b;
    if (in_item.frame_end)      row_next = '0;
    else if (in_item.row_end)   row_next = (r == RowMax) ? r : r + 13'd1;
    else                        row_next = r;
    if (in_item.frame_end)      cur_plane_next = PLANE_LUMA;
    else if (chg)               cur_plane_next = in_item.plane;
    else                        cur_plane_next = cur_plane;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      cur_plane <= PLANE_LUMA;
      lb0       <= '0;
      lb1       <= '0;
      fill      <= '0;
    end else if (in_fire) begin
      col       <= col_next;
      row       <= row_next;
      cur_plane <= cur_plane_next;
      lb0       <= lb0_next;
      lb1       <= lb1_next;
      fill      <= fill_next;
    end
  end

endmodule

[rtl/core/vfc_queue.sv]
// ----------------------------------------------------------------------------
// vfc_queue
// Small result queue that drives the output channel.
// ----------------------------------------------------------------------------
module vfc_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  vfc_pkg::item_t          push_item,
  input  logic                    pop_ready,
  output logic                    out_valid,
  output vfc_pkg::item_t          out_item,
  output logic                    space,
  output logic [vfc_pkg::QAw:0]   level
);
  import vfc_pkg::*;

  item_t          mem [QDepth];
  logic [QAw-1:0] wr_ptr;
  logic [QAw-1:0] rd_ptr;
  logic           pop;

  assign out_valid = (level != '0);
  assign out_item  = mem[rd_ptr];
  assign pop       = out_valid && pop_ready;
  assign space     = (level != (QAw+1)'(QDepth));

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QAw'(1);
      if (pop)  rd_ptr <= rd_ptr + QAw'(1);
      level <= level + (QAw+1)'(push) - (QAw+1)'(pop);
    end
  end

endmodule

[rtl/core/video_frame_crop_stream_core.sv]
// ----------------------------------------------------------------------------
// video_frame_crop_stream_core
// Crop window over a raster byte stream of raw video frames.
// ----------------------------------------------------------------------------
// Takes one byte per clock while the input is not stalled, and forwards only
// the bytes that fall inside the crop window. The front stage decides each
// byte in the cycle it is accepted; a kept byte lands in a 4-entry queue and
// shows on the m_ side in the next cycle when that queue was empty.
// The input stalls only when that queue is full, in the cycle after each
// configuration write while the window bounds are recomputed, and in the cycle
// after reset. With an odd left trim in packed 4:2:2 the luma bytes are taken
// from two bytes further on, so each kept byte leaves two input bytes after
// its window position; window bytes still in the delay when a row ends early
// are dropped. Layout 3 acts as packed simple. Output frame end is flagged
// only on the last byte of the last window row (of plane 2 in planar mode).
// ----------------------------------------------------------------------------
module video_frame_crop_stream_core #(
  parameter int MAX_DIM = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // input bytes
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] pixel_byte
  input  logic        s_tlast,   // row_end
  input  logic [2:0]  s_tuser,   // [1:0] plane_index, [2] frame_end
  // cropped bytes
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,   // out_row_end
  output logic [2:0]  m_tuser,   // [1:0] out_plane, [2] out_frame_end
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import vfc_pkg::*;

  crop_cfg_t    win;
  logic         cfg_busy;
  logic         in_fire;
  item_t        in_item;
  logic         push;
  item_t        push_item;
  item_t        out_item;
  logic         q_space;
  logic [QAw:0] q_level;

  // front can produce at most one result per item, so one free slot suffices
  assign s_tready = q_space && !cfg_busy;
  assign in_fire  = s_tvalid && s_tready;

  assign in_item.data      = s_tdata;
  assign in_item.plane     = s_tuser[1:0];
  assign in_item.row_end   = s_tlast;
  assign in_item.frame_end = s_tuser[2];

  vfc_cfg #(
    .MAX_DIM(MAX_DIM)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .win       (win),
    .busy      (cfg_busy)
  );

  vfc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_item   (in_item),
    .win       (win),
    .push      (push),
    .push_item (push_item)
  );

  vfc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop_ready (m_tready),
    .out_valid (m_tvalid),
    .out_item  (out_item),
    .space     (q_space),
    .level     (q_level)
  );

  assign m_tdata = out_item.data;
  assign m_tlast = out_item.row_end;
  assign m_tuser = {out_item.frame_end, out_item.plane};

  // a result enters the queue only for an accepted item
  a_push_on_accept: assert property (@(posedge clk) disable iff (rst)
    push |-> in_fire)
    else $error("result pushed without an accepted item");

  // queue never holds more than its depth
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_level <= (QAw+1)'(QDepth))
    else $error("result queue overflow");

  // bounds are recomputed before the next item is taken
  a_cfg_settle: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> !in_fire)
    else $error("item accepted before window bounds settled");

  // the frame end mark only sits on the last byte of a row
  a_frame_end_row: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2]) |-> m_tlast)
    else $error("frame end without row end");

endmodule
